### design/spq_pkg.sv
// ---------------------------------------------------------------------------
// spq_pkg: shared types and codes for the sorted priority queue
// Request and status codes, fixed field widths and the per-cycle cell command.
// ---------------------------------------------------------------------------
package spq_pkg;

    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 8;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic REQ_ENQ = 1'b0;
    localparam logic REQ_DEQ = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // command broadcast to every cell of the chain
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

### design/spq_cell.sv
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue chain
// Holds one value and priority; on an insert it keeps, takes the new entry or
// takes its left neighbor; on a removal it takes its right neighbor.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int PW = 8
) (
    input  logic               i_clk,
    input  t_cell_ctrl         i_ctrl,
    input  logic               i_valid,
    input  logic [VALUE_W-1:0] i_new_value,
    input  logic [PW-1:0]      i_new_prio,
    input  logic               i_left_keep,
    input  logic [VALUE_W-1:0] i_left_value,
    input  logic [PW-1:0]      i_left_prio,
    input  logic [VALUE_W-1:0] i_right_value,
    input  logic [PW-1:0]      i_right_prio,
    output logic               o_keep,
    output logic [VALUE_W-1:0] o_value,
    output logic [PW-1:0]      o_prio
);

    logic [VALUE_W-1:0] r_value, n_value;
    logic [PW-1:0]      r_prio,  n_prio;

    // equal priority stays ahead of the newcomer
    assign o_keep  = i_valid && (r_prio >= i_new_prio);
    assign o_value = r_value;
    assign o_prio  = r_prio;

    always_comb begin
        n_value = r_value;
        n_prio  = r_prio;
        priority if (i_ctrl.enq) begin
            if (!o_keep) begin
                if (i_left_keep) begin
                    n_value = i_new_value;
                    n_prio  = i_new_prio;
                end else begin
                    n_value = i_left_value;
                    n_prio  = i_left_prio;
                end
            end
        end else if (i_ctrl.deq) begin
            n_value = i_right_value;
            n_prio  = i_right_prio;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_prio  <= n_prio;
    end

endmodule

### design/sorted_priority_queue_top.sv
// ---------------------------------------------------------------------------
// sorted_priority_queue_top: shift-register priority queue
// A row of DEPTH cells kept in descending priority order, oldest first among
// equal priorities. Enqueue inserts the new entry in order, dequeue pops the head.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  request  | start, busy         | i_req_type, i_in_value, i_in_priority
//  result   | o_done (1 cycle)    | o_status, o_out_value, o_out_priority,
//           |                     | o_occupancy
//
// One request per cycle while busy is low: every cell compares its priority
// against the new one at once, so a request finishes in the cycle it is taken
// and its result shows in the next cycle. busy is high only during reset.
// Reset clears the fill count and the result strobe; cell contents stay as is.
// The result cannot be stalled: it is valid for exactly one cycle.
// ---------------------------------------------------------------------------
module sorted_priority_queue_top
    import spq_pkg::*;
#(
    parameter int DEPTH         = 16,
    parameter int PRIORITY_BITS = 8,
    localparam int CNT_W        = $clog2(DEPTH + 1)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_req_type,
    input  logic signed [VALUE_W-1:0]  i_in_value,
    input  logic        [PRIO_W-1:0]   i_in_priority,
    output logic                       o_done,
    output logic        [STATUS_W-1:0] o_status,
    output logic signed [VALUE_W-1:0]  o_out_value,
    output logic        [PRIO_W-1:0]   o_out_priority,
    output logic        [CNT_W-1:0]    o_occupancy
);

    localparam int PW = PRIORITY_BITS;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic                 accept;
    logic                 is_full, is_empty;
    t_cell_ctrl           ctrl;
    logic [PRIO_W+PW-1:0] in_prio_ext;
    logic [PW-1:0]        new_prio;
    logic [PRIO_W+PW-1:0] head_prio_ext;

    logic [DEPTH-1:0]   keep;
    logic [VALUE_W-1:0] cell_value [DEPTH];
    logic [PW-1:0]      cell_prio  [DEPTH];

    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_done;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [VALUE_W-1:0]  r_out_value, n_out_value;
    logic [PRIO_W-1:0]   r_out_prio, n_out_prio;

    assign busy     = !i_rst_n;
    assign accept   = start && !busy;
    assign is_full  = (r_count == FULL_CNT);
    assign is_empty = (r_count == '0);

    // drop priority bits above the configured width, or zero-extend
    assign in_prio_ext   = {{PW{1'b0}}, i_in_priority};
    assign new_prio      = in_prio_ext[PW-1:0];
    assign head_prio_ext = {{PRIO_W{1'b0}}, cell_prio[0]};

    assign ctrl.enq = accept && (i_req_type == REQ_ENQ) && !is_full;
    assign ctrl.deq = accept && (i_req_type == REQ_DEQ) && !is_empty;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic               valid;
        logic               left_keep;
        logic [VALUE_W-1:0] left_value, right_value;
        logic [PW-1:0]      left_prio, right_prio;

        assign valid = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_first
            assign left_keep  = 1'b1;
            assign left_value = i_in_value;
            assign left_prio  = new_prio;
        end else begin : g_mid
            assign left_keep  = keep[g-1];
            assign left_value = cell_value[g-1];
            assign left_prio  = cell_prio[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_value = '0;
            assign right_prio  = '0;
        end else begin : g_inner
            assign right_value = cell_value[g+1];
            assign right_prio  = cell_prio[g+1];
        end

        spq_cell #(
            .PW (PW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_valid       (valid),
            .i_new_value   (i_in_value),
            .i_new_prio    (new_prio),
            .i_left_keep   (left_keep),
            .i_left_value  (left_value),
            .i_left_prio   (left_prio),
            .i_right_value (right_value),
            .i_right_prio  (right_prio),
            .o_keep        (keep[g]),
            .o_value       (cell_value[g]),
            .o_prio        (cell_prio[g])
        );
    end

    always_comb begin
        n_count     = r_count;
        n_status    = ST_OK;
        n_out_value = '0;
        n_out_prio  = '0;
        unique case (i_req_type)
            REQ_ENQ: begin
                if (is_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            REQ_DEQ: begin
                if (is_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count     = r_count - 1'b1;
                    n_out_value = cell_value[0];
                    n_out_prio  = head_prio_ext[PRIO_W-1:0];
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_done <= accept;
            if (accept) begin
                r_count <= n_count;
            end
        end
    end

    // hold the last result between requests
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status    <= n_status;
            r_out_value <= n_out_value;
            r_out_prio  <= n_out_prio;
        end
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_out_value    = r_out_value;
    assign o_out_priority = r_out_prio;
    assign o_occupancy    = r_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("fill count above depth");

    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("request without result strobe");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && (o_status != ST_OK) |-> (o_out_value == '0) && (o_out_priority == '0))
        else $error("refused request returned data");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctrl.deq |=> (r_count == $past(r_count) - 1'b1) && (o_status == ST_OK))
        else $error("dequeue did not drop one entry");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_req_type == REQ_ENQ) && is_full |=> (r_count == FULL_CNT)
            && (o_status == ST_FULL))
        else $error("enqueue on full queue changed state");

endmodule
